// File: rtl/core/irhc_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 receive header check: shared types and constants
// Word layouts for both channels, verdict codes, header byte positions and
// the fixed limits that the header checks compare against.
// ----------------------------------------------------------------------------
package irhc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [5:0]  header_bytes;
    logic [31:0] source_address;
  } out_word_t;

  // Verdict codes.
  localparam logic [2:0] VERDICT_ICMP       = 3'd0;
  localparam logic [2:0] VERDICT_UDP        = 3'd1;
  localparam logic [2:0] VERDICT_PROTO_UNRCH = 3'd2;
  localparam logic [2:0] VERDICT_BAD_HDR    = 3'd3;
  localparam logic [2:0] VERDICT_BAD_CKSUM  = 3'd4;
  localparam logic [2:0] VERDICT_NOT_OURS   = 3'd5;

  // Header byte positions.
  localparam logic [5:0] POS_VER_IHL   = 6'd0;
  localparam logic [5:0] POS_TOTLEN_LO = 6'd3;
  localparam logic [5:0] POS_PROTOCOL  = 6'd9;
  localparam logic [5:0] POS_CKSUM_LO  = 6'd11;
  localparam logic [5:0] POS_SRC_FIRST = 6'd12;
  localparam logic [5:0] POS_SRC_LAST  = 6'd15;
  localparam logic [5:0] POS_DST_FIRST = 6'd16;
  localparam logic [5:0] POS_DST_LAST  = 6'd19;

  // Limits and protocol numbers.
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [15:0] MIN_TOTAL_LEN = 16'd20;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  BCAST_OCTET   = 8'hff;

endpackage

// File: rtl/core/irhc_hdr_track.sv
// ----------------------------------------------------------------------------
// IPv4 receive header check: header tracker
// Holds the per-packet header state, folds each byte into it and works out
// the verdict on the byte that completes (or fails) the header.
// ----------------------------------------------------------------------------
module irhc_hdr_track
  import irhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  in_word_t    in_word,
  input  logic [31:0] local_address,
  output logic        res_valid,
  output out_word_t   res_word
);

  logic        in_hdr_r, in_hdr_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [3:0]  lw_r, lw_nxt;
  logic        ver_ok_r, ver_ok_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] cksum_r, cksum_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic        start;
  logic        active;
  logic [7:0]  b;
  logic [5:0]  pos;
  logic [3:0]  lw_b;
  logic        ver_b;
  logic [15:0] sum_b;
  logic [7:0]  hold_b;
  logic [15:0] cksum_b;
  logic [7:0]  proto_b;
  logic [31:0] src_b;
  logic [31:0] dst_b;
  logic [15:0] pair;
  logic [16:0] sum_wide;
  logic [31:0] bcast;

  assign start  = in_word.packet_start;
  assign b      = in_word.data_byte;
  assign active = start | in_hdr_r;
  assign bcast  = {local_address[31:8], BCAST_OCTET};

  always_comb begin
    // A start flag discards whatever was gathered so far.
    pos     = start ? '0 : pos_r;
    lw_b    = start ? '0 : lw_r;
    ver_b   = start ? 1'b0 : ver_ok_r;
    sum_b   = start ? '0 : sum_r;
    hold_b  = start ? '0 : hold_r;
    cksum_b = start ? '0 : cksum_r;
    proto_b = start ? '0 : proto_r;
    src_b   = start ? '0 : src_r;
    dst_b   = start ? '0 : dst_r;

    pair     = {hold_b, b};
    // The checksum field itself counts as zero in the sum.
    sum_wide = {1'b0, sum_b} + ((pos == POS_CKSUM_LO) ? 17'd0 : {1'b0, pair});

    in_hdr_nxt = in_hdr_r;
    pos_nxt    = pos_r;
    lw_nxt     = lw_r;
    ver_ok_nxt = ver_ok_r;
    sum_nxt    = sum_r;
    hold_nxt   = hold_r;
    cksum_nxt  = cksum_r;
    proto_nxt  = proto_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;

    res_valid               = 1'b0;
    res_word.verdict        = VERDICT_BAD_HDR;
    res_word.header_bytes   = {lw_b, 2'b00};
    res_word.source_address = '0;

    if (active) begin
      in_hdr_nxt = 1'b1;
      pos_nxt    = pos + 6'd1;
      lw_nxt     = lw_b;
      ver_ok_nxt = ver_b;
      sum_nxt    = sum_b;
      hold_nxt   = hold_b;
      cksum_nxt  = cksum_b;
      proto_nxt  = proto_b;
      src_nxt    = src_b;
      dst_nxt    = dst_b;

      if (pos == POS_VER_IHL) begin
        ver_ok_nxt = (b[7:4] == IP_VERSION);
        lw_nxt     = b[3:0];
      end
      if (pos == POS_PROTOCOL) begin
        proto_nxt = b;
      end
      if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) begin
        src_nxt = {src_b[23:0], b};
      end
      if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
        dst_nxt = {dst_b[23:0], b};
      end

      if (!pos[0]) begin
        hold_nxt = b;
      end else begin
        // Ones' complement add: the end-around carry cannot overflow again.
        sum_nxt = sum_wide[15:0] + {15'd0, sum_wide[16]};
        if (pos == POS_CKSUM_LO) begin
          cksum_nxt = pair;
        end
      end

      if (pos == POS_TOTLEN_LO &&
          (!ver_b || lw_b < MIN_IHL || pair < MIN_TOTAL_LEN)) begin
        in_hdr_nxt              = 1'b0;
        res_valid               = 1'b1;
        res_word.verdict        = VERDICT_BAD_HDR;
        res_word.source_address = '0;
      end else if (pos == {lw_b - 4'd1, 2'b11}) begin
        // Only reachable for a length of at least five words.
        in_hdr_nxt              = 1'b0;
        res_valid               = 1'b1;
        res_word.source_address = src_nxt;
        if (~sum_nxt != cksum_b) begin
          res_word.verdict = VERDICT_BAD_CKSUM;
        end else if (dst_nxt != local_address && dst_nxt != bcast) begin
          res_word.verdict = VERDICT_NOT_OURS;
        end else if (proto_b == PROTO_ICMP) begin
          res_word.verdict = VERDICT_ICMP;
        end else if (proto_b == PROTO_UDP) begin
          res_word.verdict = VERDICT_UDP;
        end else begin
          res_word.verdict = VERDICT_PROTO_UNRCH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hdr_r <= 1'b0;
      pos_r    <= '0;
    end else if (byte_en) begin
      in_hdr_r <= in_hdr_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      lw_r     <= lw_nxt;
      ver_ok_r <= ver_ok_nxt;
      sum_r    <= sum_nxt;
      hold_r   <= hold_nxt;
      cksum_r  <= cksum_nxt;
      proto_r  <= proto_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
    end
  end

endmodule

// File: rtl/core/ipv4_receive_header_check.sv
// ----------------------------------------------------------------------------
// IPv4 receive header check
// Checks received IPv4 headers byte by byte and gives one verdict word per
// packet, with the header length and the source address.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Word
//  in_      input      in_valid/in_ready   in_word_t: data_byte, packet_start
//  out_     output     out_valid/out_ready out_word_t: verdict, header_bytes,
//                                          source_address
//  cfg_     input      cfg_we              cfg_wdata: local address
//
// One byte is taken every cycle while in_ready is high; the verdict appears
// in the output register the cycle after the byte that completes the header
// (or fails it at byte 3). in_ready is low only while a verdict waits and
// out_ready is low. Reset (rst_n low, synchronous) clears the local address
// and sets the block idle until the next start flag.
// ----------------------------------------------------------------------------
module ipv4_receive_header_check
  import irhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] local_addr_r;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r;
  logic        accept;
  logic        res_valid;
  out_word_t   res_word;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  irhc_hdr_track u_hdr_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_en       (accept),
    .in_word       (in_word),
    .local_address (local_addr_r),
    .res_valid     (res_valid),
    .res_word      (res_word)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        local_addr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_word_r <= res_word;
    end
  end

endmodule
